// File: hw/rtl/assert_macros.svh
// Assertion helpers for the checker file of this block.
// Each macro takes a label, a clock, an active-low reset, a condition and
// a consequence, and reports a failure through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequence must hold in the same cycle as the condition.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequence must hold in the cycle after the condition.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: hw/rtl/dpsf_pkg.sv
// ----------------------------------------------------------------------------
// dpsf_pkg
// Shared types, codes and default parameters of the physical segment finder.
// ----------------------------------------------------------------------------
package dpsf_pkg;

    // Default sizing of the frame table and of one page.
    localparam int DEF_MAX_PAGES  = 256;
    localparam int DEF_PAGE_BYTES = 4096;

    // Field widths.
    localparam int FRAME_W  = 20;
    localparam int OFFSET_W = 20;
    localparam int LEN_W    = 21;
    localparam int ADDR_W   = 32;
    localparam int START_W  = 12;
    localparam int COUNT_W  = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 21;

    // Width of the shared add/subtract unit: holds a signed byte distance.
    localparam int ALU_W = 23;

    // Operation codes of an input item.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT    = 2'd2;

    // One input item.
    typedef struct packed {
        logic                opcode;
        logic [7:0]          page_index;
        logic [FRAME_W-1:0]  frame_number;
        logic [OFFSET_W-1:0] byte_offset;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [ADDR_W-1:0] physical_address;
        logic [LEN_W-1:0]  segment_length;
    } out_item_t;

    // Operation request to the shared add/subtract unit.
    typedef struct packed {
        logic                    sub;
        logic signed [ALU_W-1:0] a;
        logic signed [ALU_W-1:0] b;
    } alu_req_t;

endpackage

// File: hw/rtl/dpsf_frame_ram.sv
// ----------------------------------------------------------------------------
// dpsf_frame_ram
// Frame number table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dpsf_frame_ram
    import dpsf_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_PAGES,
    parameter int IDX_W = 8
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_addr,
    input  logic [FRAME_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [IDX_W-1:0]   rd_addr,
    output logic [FRAME_W-1:0] rd_data
);

    logic [FRAME_W-1:0] mem [DEPTH];
    logic [FRAME_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with output register.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/dpsf_alu.sv
// ----------------------------------------------------------------------------
// dpsf_alu
// Shared signed add/subtract unit used by every step of the query sequencer.
// ----------------------------------------------------------------------------
module dpsf_alu
    import dpsf_pkg::*;
(
    input  alu_req_t                req,
    output logic signed [ALU_W-1:0] y
);

    // One add or subtract per cycle.
    always_comb
    begin
        if (req.sub)
        begin
            y = req.a - req.b;
        end
        else
        begin
            y = req.a + req.b;
        end
    end

endmodule

// File: hw/rtl/dpsf_engine.sv
// ----------------------------------------------------------------------------
// dpsf_engine
// Query sequencer: translates a byte offset and walks the frame table one
// entry per cycle, using a single shared add/subtract unit.
// ----------------------------------------------------------------------------
module dpsf_engine
    import dpsf_pkg::*;
#(
    parameter int MAX_PAGES  = DEF_MAX_PAGES,
    parameter int PAGE_BYTES = DEF_PAGE_BYTES,
    parameter int IDX_W      = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                query,
    input  logic [OFFSET_W-1:0] byte_offset,
    input  logic [START_W-1:0]  start_offset,
    input  logic [LEN_W-1:0]    buffer_length,
    input  logic [COUNT_W-1:0]  page_count,
    output logic                busy,
    output logic                rd_en,
    output logic [IDX_W-1:0]    rd_addr,
    input  logic [FRAME_W-1:0]  rd_data,
    output logic                result_strobe,
    output out_item_t           result
);

    localparam int OFF_W = $clog2(PAGE_BYTES);
    localparam int VPOS_W = 21;

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SUB   = 3'd1;
    localparam logic [2:0] S_VPOS  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_FIRST = 3'd4;
    localparam logic [2:0] S_WALK  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    localparam logic signed [ALU_W-1:0] PB_ALU  = ALU_W'(PAGE_BYTES);
    localparam logic [VPOS_W-1:0]       PB_MASK = VPOS_W'(PAGE_BYTES - 1);
    localparam logic [VPOS_W-1:0]       MAXP_V  = VPOS_W'(MAX_PAGES);

    logic [2:0]              state_reg, state_next;
    logic [OFFSET_W-1:0]     pos_reg, pos_next;
    logic [LEN_W-1:0]        remain_reg, remain_next;
    logic [VPOS_W-1:0]       vpos_reg, vpos_next;
    logic signed [ALU_W-1:0] gap_reg, gap_next;
    logic [FRAME_W-1:0]      prev_reg, prev_next;
    logic [FRAME_W-1:0]      base_reg, base_next;
    logic [VPOS_W-1:0]       k_reg, k_next;
    logic                    strobe_reg, strobe_next;
    out_item_t               result_reg, result_next;

    alu_req_t                alu_req;
    logic signed [ALU_W-1:0] alu_y;
    logic                    alu_pos;
    logic [VPOS_W-1:0]       start_mod;
    logic [VPOS_W-1:0]       limit;
    logic [VPOS_W-1:0]       page;
    logic [OFF_W-1:0]        inpage;
    logic [VPOS_W-1:0]       rd_k;
    logic                    contiguous;
    logic                    gap_pos;

    dpsf_alu u_alu
    (
        .req (alu_req),
        .y   (alu_y)
    );

    // Derived values of the current query.
    assign start_mod  = {{(VPOS_W - START_W){1'b0}}, start_offset} & PB_MASK;
    assign limit      = ({{(VPOS_W - COUNT_W){1'b0}}, page_count} > MAXP_V)
                        ? MAXP_V : {{(VPOS_W - COUNT_W){1'b0}}, page_count};
    assign page       = vpos_reg >> OFF_W;
    assign inpage     = vpos_reg[OFF_W-1:0];
    assign alu_pos    = !alu_y[ALU_W-1] && (alu_y != '0);
    assign gap_pos    = !gap_reg[ALU_W-1] && (gap_reg != '0);
    assign contiguous = ({1'b0, rd_data} == ({1'b0, prev_reg} + 21'd1));

    // Sequencer and operand selection for the shared unit.
    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        remain_next = remain_reg;
        vpos_next   = vpos_reg;
        gap_next    = gap_reg;
        prev_next   = prev_reg;
        base_next   = base_reg;
        k_next      = k_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        alu_req     = '0;
        rd_en       = 1'b0;
        rd_k        = k_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (query)
                begin
                    pos_next   = byte_offset;
                    state_next = S_SUB;
                end
            end
            // Bytes left from the offset to the buffer end.
            S_SUB:
            begin
                alu_req.sub = 1'b1;
                alu_req.a   = $signed({2'b00, buffer_length});
                alu_req.b   = $signed({3'b000, pos_reg});
                remain_next = alu_y[LEN_W-1:0];
                if (!alu_pos)
                begin
                    result_next = '0;
                    strobe_next = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_VPOS;
                end
            end
            // Offset from the start of the first page.
            S_VPOS:
            begin
                alu_req.sub = 1'b0;
                alu_req.a   = $signed({2'b00, start_mod});
                alu_req.b   = $signed({3'b000, pos_reg});
                vpos_next   = alu_y[VPOS_W-1:0];
                state_next  = S_READ;
            end
            // Bytes to the end of the offset's page; fetch its frame, or give an empty result beyond the table.
            S_READ:
            begin
                alu_req.sub = 1'b1;
                alu_req.a   = PB_ALU;
                alu_req.b   = $signed(ALU_W'(inpage));
                gap_next    = alu_y;
                if (page >= limit)
                begin
                    result_next = '0;
                    strobe_next = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_k       = page;
                    k_next     = page + 21'd1;
                    state_next = S_FIRST;
                end
            end
            // First frame arrives; gap becomes remaining bytes beyond the run.
            S_FIRST:
            begin
                alu_req.sub = 1'b1;
                alu_req.a   = $signed({2'b00, remain_reg});
                alu_req.b   = gap_reg;
                gap_next    = alu_y;
                base_next   = rd_data;
                prev_next   = rd_data;
                if ((k_reg < limit) && alu_pos)
                begin
                    rd_en      = 1'b1;
                    rd_k       = k_reg;
                    state_next = S_WALK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            // One following entry per cycle while frames stay consecutive.
            S_WALK:
            begin
                alu_req.sub = 1'b1;
                alu_req.a   = gap_reg;
                alu_req.b   = PB_ALU;
                if (contiguous)
                begin
                    gap_next  = alu_y;
                    prev_next = rd_data;
                    k_next    = k_reg + 21'd1;
                    if (((k_reg + 21'd1) < limit) && alu_pos)
                    begin
                        rd_en = 1'b1;
                        rd_k  = k_reg + 21'd1;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            // Clip the run at the buffer end and present the result.
            S_DONE:
            begin
                alu_req.sub = 1'b1;
                alu_req.a   = $signed({2'b00, remain_reg});
                alu_req.b   = gap_reg;
                result_next.physical_address = (ADDR_W'(base_reg) << OFF_W)
                                               | ADDR_W'(inpage);
                result_next.segment_length   = gap_pos ? alu_y[LEN_W-1:0] : remain_reg;
                strobe_next = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rd_addr = rd_k[IDX_W-1:0];

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        remain_reg <= remain_next;
        vpos_reg   <= vpos_next;
        gap_reg    <= gap_next;
        prev_reg   <= prev_next;
        base_reg   <= base_next;
        k_reg      <= k_next;
        result_reg <= result_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_strobe = strobe_reg;
    assign result        = result_reg;

endmodule

// File: hw/rtl/dma_physical_segment_finder.sv
// Load command: taken without a result; busy stays low.
// Query: the sequencer runs SUB, VPOS, READ, FIRST, a WALK step for each further table entry read, then DONE;
// it ends in SUB when the offset is past the end and in READ when the page lies beyond the table.
// Busy falls as the strobe rises, so the next command can transfer at the edge that accepts the
// result; the receiver cannot stall. One table entry is read per cycle during the walk.
// Reset clears the sequencer, the strobe and all configuration registers; the table is undefined.
// ----------------------------------------------------------------------------
// dma_physical_segment_finder
// Translates a buffer offset to a physical address and finds the length of
// the physically contiguous segment that starts there.
// ----------------------------------------------------------------------------
module dma_physical_segment_finder
    import dpsf_pkg::*;
#(
    parameter int MAX_PAGES  = DEF_MAX_PAGES,
    parameter int PAGE_BYTES = DEF_PAGE_BYTES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  in_item_t              item,
    output logic                  result_strobe,
    output out_item_t             result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

    logic [START_W-1:0] start_offset_reg;
    logic [LEN_W-1:0]   buffer_length_reg;
    logic [COUNT_W-1:0] page_count_reg;

    logic               accept;
    logic               load_wr;
    logic               query;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [FRAME_W-1:0] rd_data;

    // Command decode.
    assign accept  = start && !busy;
    assign query   = accept && (item.opcode == OP_QUERY);
    assign load_wr = accept && (item.opcode == OP_LOAD)
                     && (32'(item.page_index) < MAX_PAGES);

    // Configuration registers, written only while no query runs.
    assign cfg_ready = !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_offset_reg  <= '0;
            buffer_length_reg <= '0;
            page_count_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_START_OFFSET:  start_offset_reg  <= cfg_data[START_W-1:0];
                CFG_BUFFER_LENGTH: buffer_length_reg <= cfg_data[LEN_W-1:0];
                CFG_PAGE_COUNT:    page_count_reg    <= cfg_data[COUNT_W-1:0];
                default:           ;
            endcase
        end
    end

    // Frame number table.
    dpsf_frame_ram #(
        .DEPTH (MAX_PAGES),
        .IDX_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (load_wr),
        .wr_addr (IDX_W'(item.page_index)),
        .wr_data (item.frame_number),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Query sequencer.
    dpsf_engine #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (PAGE_BYTES),
        .IDX_W      (IDX_W)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .query         (query),
        .byte_offset   (item.byte_offset),
        .start_offset  (start_offset_reg),
        .buffer_length (buffer_length_reg),
        .page_count    (page_count_reg),
        .busy          (busy),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .result_strobe (result_strobe),
        .result        (result)
    );

endmodule

// File: hw/rtl/dpsf_checker.sv
// ----------------------------------------------------------------------------
// dpsf_checker
// Port-level checks of the segment finder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dpsf_checker
    import dpsf_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input in_item_t  item,
    input logic      result_strobe,
    input out_item_t result
);

    // A query always passes the subtract state before its result, so results never come back to back.
    `ASSERT_NEXT(a_no_back_to_back, clk, rst_n, result_strobe, !result_strobe)

    // An accepted query makes the block busy.
    `ASSERT_NEXT(a_query_busy, clk, rst_n, start && !busy && (item.opcode == OP_QUERY), busy)

    // A load transfer finishes at once and produces no result.
    `ASSERT_NEXT(a_load_quiet, clk, rst_n, start && !busy && (item.opcode == OP_LOAD), !busy && !result_strobe)

    // An empty segment carries a zero address.
    `ASSERT_SAME(a_empty_zero, clk, rst_n, result_strobe && (result.segment_length == '0), result.physical_address == '0)

endmodule

bind dma_physical_segment_finder dpsf_checker u_dpsf_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .result_strobe (result_strobe),
    .result        (result)
);

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the physical segment finder. Table loads and
// segment queries are queued by a stimulus block, sent by a driver with
// random idle bursts, and every query is predicted from a local copy of the
// frame table and the configuration. Each strobed result is compared with
// the oldest predicted segment.
// ----------------------------------------------------------------------------
module tb_top;
    import dpsf_pkg::*;

    localparam int PAGE        = DEF_PAGE_BYTES;
    localparam int TABLE_DEPTH = DEF_MAX_PAGES;
    localparam int FRAME_MAX   = (1 << FRAME_W) - 1;
    localparam int OFFSET_MAX  = (1 << OFFSET_W) - 1;
    localparam int LEN_MAX     = (1 << LEN_W) - 1;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    in_item_t              item;
    logic                  result_strobe;
    out_item_t             result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Commands waiting to be sent, and segments waiting to come back.
    in_item_t  cmd_queue[$];
    out_item_t seg_expect[$];

    // Local copy of the block's table and registers, updated on each transfer.
    logic [FRAME_W-1:0]  frame_copy [0:TABLE_DEPTH-1];
    logic [START_W-1:0]  cur_start;
    logic [LEN_W-1:0]    cur_len;
    logic [COUNT_W-1:0]  cur_pages;

    // Buffer length as seen by the stimulus side, used to pick useful offsets.
    int gen_len;

    int    mismatch_cnt;
    int    queued_items;
    int    taken_cnt;
    int    taken_seen;
    int    gap_left;
    logic  steady;

    dma_physical_segment_finder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .result_strobe (result_strobe),
        .result        (result),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    // Address and contiguous length of the segment that holds a byte offset.
    function automatic out_item_t locate_segment(input logic [OFFSET_W-1:0] offs);
        out_item_t         seg;
        longint unsigned   lim;
        longint unsigned   vpos;
        longint unsigned   pg;
        longint unsigned   inpg;
        longint unsigned   remain;
        longint unsigned   run;
        longint unsigned   k;
        longint unsigned   addr;
        logic              contig;
        seg = '0;
        if (offs >= cur_len)
            return seg;
        lim = (cur_pages > TABLE_DEPTH) ? TABLE_DEPTH : cur_pages;
        vpos = (cur_start % PAGE) + offs;
        pg = vpos / PAGE;
        inpg = vpos % PAGE;
        if (pg >= lim)
            return seg;
        remain = cur_len - offs;
        run = PAGE - inpg;
        contig = 1'b1;
        // Frames do not wrap, so compare in a wider type.
        for (k = pg + 1; k < lim && run < remain && contig; k++) begin
            if (longint'(frame_copy[k]) != longint'(frame_copy[k - 1]) + 1)
                contig = 1'b0;
            else
                run += PAGE;
        end
        if (run > remain)
            run = remain;
        addr = longint'(frame_copy[pg]) * PAGE + inpg;
        seg.physical_address = addr[ADDR_W-1:0];
        seg.segment_length = run[LEN_W-1:0];
        return seg;
    endfunction

    // Monitor: register writes, command transfers and result checks.
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_START_OFFSET:  cur_start = cfg_data[START_W-1:0];
                    CFG_BUFFER_LENGTH: cur_len = cfg_data[LEN_W-1:0];
                    CFG_PAGE_COUNT:    cur_pages = cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy) begin
                if (item.opcode == OP_LOAD) begin
                    if (item.page_index < TABLE_DEPTH)
                        frame_copy[item.page_index] = item.frame_number;
                end else begin
                    seg_expect.push_back(locate_segment(item.byte_offset));
                end
                void'(cmd_queue.pop_front());
                taken_cnt++;
            end
            if (result_strobe) begin
                if (seg_expect.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result: addr %h len %0d",
                                 result.physical_address, result.segment_length);
                end else begin
                    out_item_t want;
                    want = seg_expect.pop_front();
                    if (result.physical_address !== want.physical_address ||
                        result.segment_length !== want.segment_length) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("segment mismatch: expected addr %h len %0d, got addr %h len %0d",
                                     want.physical_address, want.segment_length,
                                     result.physical_address, result.segment_length);
                    end
                end
            end
        end
    end

    // Driver: holds a command until its transfer, then may idle for a burst.
    always @(negedge clk) begin
        if (rst_n) begin
            if (!(start && taken_cnt == taken_seen)) begin
                taken_seen = taken_cnt;
                if (gap_left == 0 && !steady && cmd_queue.size() != 0 &&
                    $urandom_range(0, 5) == 0)
                    gap_left = $urandom_range(1, 17);
                if (gap_left != 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (cmd_queue.size() != 0) begin
                    start <= 1'b1;
                    item <= cmd_queue[0];
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    task automatic queue_load(input int idx, input int frame);
        in_item_t cmd;
        cmd.opcode = OP_LOAD;
        cmd.page_index = idx[7:0];
        cmd.frame_number = frame[FRAME_W-1:0];
        cmd.byte_offset = $urandom_range(0, OFFSET_MAX);
        cmd_queue.push_back(cmd);
        queued_items++;
    endtask

    task automatic queue_query(input int offs);
        in_item_t cmd;
        cmd.opcode = OP_QUERY;
        cmd.page_index = $urandom_range(0, 255);
        cmd.frame_number = $urandom_range(0, FRAME_MAX);
        cmd.byte_offset = offs[OFFSET_W-1:0];
        cmd_queue.push_back(cmd);
        queued_items++;
    endtask

    // Wait until every command is taken and every segment has come back.
    task automatic drain();
        while (cmd_queue.size() != 0 || seg_expect.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input int s, input int len, input int pages);
        write_reg(CFG_START_OFFSET, s);
        write_reg(CFG_BUFFER_LENGTH, len);
        write_reg(CFG_PAGE_COUNT, pages);
        gen_len = len;
    endtask

    // Load entries 0..n-1 as runs of consecutive frames with random breaks.
    task automatic fill_table(input int n);
        int i;
        int frame;
        frame = $urandom_range(0, FRAME_MAX);
        for (i = 0; i < n; i++) begin
            if (i != 0 && $urandom_range(0, 9) < 7)
                frame = (frame + 1) & FRAME_MAX;
            else if ($urandom_range(0, 7) == 0)
                frame = FRAME_MAX;
            else
                frame = $urandom_range(0, FRAME_MAX);
            queue_load(i, frame);
        end
    endtask

    // One query or load with the mix of the random part.
    task automatic queue_random_cmd();
        int pick;
        int top;
        pick = $urandom_range(0, 99);
        if (pick < 75 && gen_len > 0) begin
            top = (gen_len - 1 > OFFSET_MAX) ? OFFSET_MAX : gen_len - 1;
            queue_query($urandom_range(0, top));
        end else if (pick < 88 && gen_len <= OFFSET_MAX) begin
            queue_query($urandom_range(gen_len, OFFSET_MAX));
        end else if (pick < 94) begin
            queue_query($urandom_range(0, OFFSET_MAX));
        end else begin
            queue_load($urandom_range(0, 255), $urandom_range(0, FRAME_MAX));
        end
    endtask

    initial begin
        int rand_base;
        int n;
        int i;
        int s;
        int pages;
        int span;
        int len;

        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cur_start = '0;
        cur_len = '0;
        cur_pages = '0;
        gen_len = 0;
        mismatch_cnt = 0;
        queued_items = 0;
        taken_cnt = 0;
        taken_seen = 0;
        gap_left = 0;
        steady = 1'b0;
        for (i = 0; i < TABLE_DEPTH; i++)
            frame_copy[i] = '0;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // Registers at reset: an empty buffer, so every offset is past the end.
        queue_query(0);
        queue_query(OFFSET_MAX);
        drain();

        // Start at the last byte of a page; frames step over the top of their
        // range, which must break the run.
        set_config(4095, 6 * PAGE, 4);
        queue_load(0, FRAME_MAX - 1);
        queue_load(1, FRAME_MAX);
        queue_load(2, 0);
        queue_load(3, 1);
        queue_load(255, 20'hABCDE);
        queue_query(0);
        queue_query(1);
        queue_query(4097);
        queue_query(3 * PAGE);
        queue_query(3 * PAGE + 1);
        queue_query(6 * PAGE - 1);
        queue_query(6 * PAGE);
        queue_query(OFFSET_MAX);
        drain();

        // Short buffer: the run is clipped at the buffer end.
        set_config(0, 100, 4);
        queue_query(0);
        queue_query(99);
        drain();

        // Full table and a buffer that covers every offset.
        set_config(0, 1 << 20, TABLE_DEPTH);
        fill_table(TABLE_DEPTH);
        queue_query(OFFSET_MAX);
        for (i = 0; i < 30; i++)
            queue_query($urandom_range(0, OFFSET_MAX));
        drain();

        // Page count above the table size and the widest length register.
        set_config($urandom_range(1, 4095), LEN_MAX, (1 << COUNT_W) - 1);
        for (i = 0; i < 20; i++)
            queue_query($urandom_range(0, OFFSET_MAX));
        drain();

        // Random phases: a fresh table layout, then mostly in-buffer queries.
        rand_base = queued_items;
        while (queued_items - rand_base < 70) begin
            if (queued_items - rand_base >= 50)
                steady = 1'b1;
            case ($urandom_range(0, 3))
                0:       s = 0;
                1:       s = 4095;
                default: s = $urandom_range(0, 4095);
            endcase
            pages = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 24);
            span = pages * PAGE - s;
            if (span < 0)
                span = 0;
            case ($urandom_range(0, 9))
                0:       len = 0;
                1:       len = $urandom_range(1, LEN_MAX);
                default: len = $urandom_range(1, span + 2 * PAGE);
            endcase
            set_config(s, len, pages);
            fill_table(pages);
            n = $urandom_range(10, 30);
            for (i = 0; i < n; i++)
                queue_random_cmd();
            drain();
        end

        repeat (300) @(posedge clk);
        if (mismatch_cnt == 0 && seg_expect.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
